### hw/rtl/lbfs_pkg.sv
package lbfs_pkg;

  localparam int NUM_LEDS_DEF = 10;
  localparam int CHANNELS     = 12;
  localparam int FRAME_LEN    = CHANNELS + 2;
  localparam int CNT_W        = $clog2(FRAME_LEN);
  localparam int LEVEL_W      = 8;
  localparam int INDEX_W      = 8;
  localparam int MASK_W       = 10;
  localparam int WORD_W       = 16;
  localparam int FUNC_W       = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 32;

  localparam logic [LEVEL_W-1:0] BRIGHTNESS_RST = 8'd192;
  localparam logic [CNT_W-1:0]   CNT_LAST       = CNT_W'(FRAME_LEN - 1);

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_WORD = 1'd1;

  localparam logic [FUNC_W-1:0] FUNC_ON         = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_OFF        = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ALL_ON     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ALL_OFF    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE_ALL = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SET_MASK   = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SET_LEVEL  = 3'd7;

  typedef struct packed {
    logic load;
    logic shift;
  } chain_ctrl_t;

endpackage

### hw/rtl/lbfs_cell.sv
module lbfs_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lbfs_pkg::chain_ctrl_t         ctrl,
  input  logic [lbfs_pkg::FUNC_W-1:0]   func,
  input  logic [lbfs_pkg::INDEX_W-1:0]  led_index,
  input  logic [lbfs_pkg::MASK_W-1:0]   state_mask,
  input  logic [lbfs_pkg::LEVEL_W-1:0]  level,
  input  logic [lbfs_pkg::LEVEL_W-1:0]  brightness,
  input  logic [lbfs_pkg::LEVEL_W-1:0]  tap_in,
  output logic [lbfs_pkg::LEVEL_W-1:0]  tap_out,
  output logic [lbfs_pkg::LEVEL_W-1:0]  level_out
);
  import lbfs_pkg::*;

  logic [LEVEL_W-1:0] led_level;
  logic [LEVEL_W-1:0] led_level_next;
  logic [LEVEL_W-1:0] tap;
  logic [MASK_W-1:0]  mask_sh;
  logic               hit;
  logic               mask_bit;
  logic               bar_on;
  logic               is_off;

  assign hit      = (led_index == INDEX_W'(INDEX));
  assign mask_sh  = state_mask >> INDEX;
  assign mask_bit = mask_sh[0];
  assign bar_on   = (INDEX_W'(INDEX) < level);
  assign is_off   = (led_level == '0);

  always_comb begin
    led_level_next = led_level;
    unique case (func)
      FUNC_ON:         if (hit) led_level_next = brightness;
      FUNC_OFF:        if (hit) led_level_next = '0;
      FUNC_TOGGLE:     if (hit) led_level_next = is_off ? brightness : '0;
      FUNC_ALL_ON:     led_level_next = brightness;
      FUNC_ALL_OFF:    led_level_next = '0;
      FUNC_TOGGLE_ALL: led_level_next = is_off ? brightness : '0;
      FUNC_SET_MASK:   led_level_next = mask_bit ? brightness : '0;
      FUNC_SET_LEVEL:  led_level_next = bar_on ? brightness : '0;
      default:         led_level_next = led_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_level <= '0;
    end else if (ctrl.load) begin
      led_level <= led_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tap <= led_level_next;
    end else if (ctrl.shift) begin
      tap <= tap_in;
    end
  end

  assign tap_out   = tap;
  assign level_out = led_level;

endmodule

### hw/rtl/lbfs_ctrl.sv
module lbfs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        out_ready,
  output logic                        in_ready,
  output logic                        busy,
  output logic [lbfs_pkg::CNT_W-1:0]  cnt,
  output lbfs_pkg::chain_ctrl_t       ctrl
);
  import lbfs_pkg::*;

  logic             busy_next;
  logic [CNT_W-1:0] cnt_next;
  logic             in_fire;
  logic             out_fire;
  logic             at_last;

  assign at_last    = (cnt == CNT_LAST);
  assign out_fire   = busy && out_ready;
  assign in_ready   = !busy || (out_fire && at_last);
  assign in_fire    = in_valid && in_ready;
  assign ctrl.load  = in_fire;
  assign ctrl.shift = out_fire && (cnt != '0);

  always_comb begin
    busy_next = busy;
    cnt_next  = cnt;
    if (in_fire) begin
      busy_next = 1'b1;
      cnt_next  = '0;
    end else if (out_fire) begin
      if (at_last) begin
        busy_next = 1'b0;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      busy <= busy_next;
      cnt  <= cnt_next;
    end
  end

endmodule

### hw/rtl/led_bar_frame_sequencer_top.sv
// LED bar frame sequencer.
// Each request on the slave stream is one command that updates the stored
// LED levels. For every command the master stream delivers a frame of 14
// words: the command word, the framed LED levels from the highest index
// down, zero pads up to twelve channel words, and a latch marker flagged by
// tuser and tlast. Every word also carries the on/off mask of the LEDs.
// The levels live in a row of cells; a frame is read out by shifting a copy
// of the levels along that row, one word per accepted output.
// The first word is valid in the cycle after the command is accepted. A new
// command is accepted in the same cycle as the latch word of the previous
// frame, so the frames of an unstalled stream follow back to back.
// When the receiver stalls, the current word holds and no command is taken
// until the frame has been drained.
// Reset clears all levels, sets brightness to 192 and the command word to 0.
// Configuration writes are taken at any time and are meant for idle periods.
module led_bar_frame_sequencer_top #(
  parameter int NUM_LEDS = lbfs_pkg::NUM_LEDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // func[2:0], led_index[10:3], state_mask[20:11], level[28:21], zeros above
  input  logic [lbfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // frame_word[15:0], led_mask[25:16], zeros above
  output logic [lbfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // is_latch[0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [lbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lbfs_pkg::*;

  localparam int FRAMED = (NUM_LEDS < CHANNELS) ? NUM_LEDS : CHANNELS;

  logic [LEVEL_W-1:0] brightness;
  logic [WORD_W-1:0]  command_word;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] led_index;
  logic [MASK_W-1:0]  state_mask;
  logic [LEVEL_W-1:0] level;
  logic               busy;
  logic [CNT_W-1:0]   cnt;
  chain_ctrl_t        ctrl;
  logic [LEVEL_W-1:0] taps   [NUM_LEDS];
  logic [LEVEL_W-1:0] levels [NUM_LEDS];
  logic [MASK_W-1:0]  led_mask;
  logic [WORD_W-1:0]  frame_word;
  logic               is_latch;

  assign func       = s_axis_tdata[2:0];
  assign led_index  = s_axis_tdata[10:3];
  assign state_mask = s_axis_tdata[20:11];
  assign level      = s_axis_tdata[28:21];

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness   <= BRIGHTNESS_RST;
      command_word <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHTNESS:   brightness   <= cfg_data[LEVEL_W-1:0];
        REG_COMMAND_WORD: command_word <= cfg_data[WORD_W-1:0];
        default:          ;
      endcase
    end
  end

  lbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .busy      (busy),
    .cnt       (cnt),
    .ctrl      (ctrl)
  );

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_cell
    logic [LEVEL_W-1:0] tap_in;
    if (i == 0) begin : g_head
      assign tap_in = '0;
    end else begin : g_link
      assign tap_in = taps[i-1];
    end
    lbfs_cell #(.INDEX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .func       (func),
      .led_index  (led_index),
      .state_mask (state_mask),
      .level      (level),
      .brightness (brightness),
      .tap_in     (tap_in),
      .tap_out    (taps[i]),
      .level_out  (levels[i])
    );
  end

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < NUM_LEDS) begin : g_led
      assign led_mask[i] = |levels[i];
    end else begin : g_none
      assign led_mask[i] = 1'b0;
    end
  end

  assign is_latch = (cnt == CNT_LAST);

  always_comb begin
    if (cnt == '0) begin
      frame_word = command_word;
    end else if (is_latch) begin
      frame_word = '0;
    end else begin
      frame_word = WORD_W'(taps[FRAMED-1]);
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {{(OUT_DATA_W - MASK_W - WORD_W){1'b0}}, led_mask, frame_word};
  assign m_axis_tuser  = is_latch;
  assign m_axis_tlast  = is_latch;

  a_last_is_latch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser && (m_axis_tdata[15:0] == '0))
    else $error("last word of a frame is not a latch marker");

  a_take_only_at_end: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && m_axis_tvalid |->
      m_axis_tready && m_axis_tlast)
    else $error("command taken while a frame is still pending");

  a_frame_starts: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid && !m_axis_tuser)
    else $error("frame does not open with the command word");

  a_mask_steady: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast && $past(m_axis_tvalid) && !$past(m_axis_tlast) |->
      (m_axis_tdata[25:16] == $past(m_axis_tdata[25:16])))
    else $error("LED mask changed inside a frame");

endmodule

### sim/led_bar_frame_sequencer_top_test.sv
`timescale 1ns / 1ps

module led_bar_frame_sequencer_top_test;
  import lbfs_pkg::*;

  localparam int NUM_LEDS    = NUM_LEDS_DEF;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              latch;
    logic              last;
    logic [MASK_W-1:0] mask;
  } frame_word_t;

  class led_frame_model;
    logic [LEVEL_W-1:0] levels[NUM_LEDS];
    logic [LEVEL_W-1:0] brightness;
    logic [WORD_W-1:0]  command_word;
    frame_word_t        expected_words[$];
    int                 errors;

    function new();
      foreach (levels[i]) levels[i] = '0;
      brightness   = BRIGHTNESS_RST;
      command_word = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BRIGHTNESS: brightness = data[LEVEL_W-1:0];
        REG_COMMAND_WORD: command_word = data[WORD_W-1:0];
        default: ;
      endcase
    endfunction

    function void apply_command(logic [IN_DATA_W-1:0] data);
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] idx;
      logic [MASK_W-1:0]  smask;
      logic [LEVEL_W-1:0] lvl;
      logic [MASK_W-1:0]  mask;
      frame_word_t        fw;
      int                 framed;
      func  = data[2:0];
      idx   = data[10:3];
      smask = data[20:11];
      lvl   = data[28:21];
      case (func)
        FUNC_ON: if (idx < NUM_LEDS) levels[idx] = brightness;
        FUNC_OFF: if (idx < NUM_LEDS) levels[idx] = '0;
        FUNC_TOGGLE: if (idx < NUM_LEDS) levels[idx] = (levels[idx] == 0) ? brightness : '0;
        FUNC_ALL_ON: foreach (levels[i]) levels[i] = brightness;
        FUNC_ALL_OFF: foreach (levels[i]) levels[i] = '0;
        FUNC_TOGGLE_ALL: foreach (levels[i]) levels[i] = (levels[i] == 0) ? brightness : '0;
        FUNC_SET_MASK: foreach (levels[i]) levels[i] = (i < MASK_W && smask[i]) ? brightness : '0;
        FUNC_SET_LEVEL: foreach (levels[i]) levels[i] = (i < lvl) ? brightness : '0;
        default: ;
      endcase
      mask = '0;
      for (int i = 0; i < NUM_LEDS && i < MASK_W; i++) mask[i] = (levels[i] != 0);
      framed = (NUM_LEDS < CHANNELS) ? NUM_LEDS : CHANNELS;
      for (int k = 0; k < FRAME_LEN; k++) begin
        fw.word  = '0;
        fw.latch = 1'b0;
        fw.last  = (k == FRAME_LEN - 1);
        fw.mask  = mask;
        if (k == 0) begin
          fw.word = command_word;
        end else if (k <= CHANNELS) begin
          if (k - 1 < framed) fw.word = WORD_W'(levels[framed - k]);
        end else begin
          fw.latch = 1'b1;
        end
        expected_words.push_back(fw);
      end
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] tdata, logic tuser, logic tlast);
      frame_word_t fw;
      if (expected_words.size() == 0) begin
        $error("frame_word: expected none, got %0h", tdata[15:0]);
        errors++;
        return;
      end
      fw = expected_words.pop_front();
      if (tdata[15:0] !== fw.word) begin
        $error("frame_word: expected %0h, got %0h", fw.word, tdata[15:0]);
        errors++;
      end
      if (tuser !== fw.latch) begin
        $error("is_latch: expected %0b, got %0b", fw.latch, tuser);
        errors++;
      end
      if (tlast !== fw.last) begin
        $error("is_last: expected %0b, got %0b", fw.last, tlast);
        errors++;
      end
      if (tdata[25:16] !== fw.mask) begin
        $error("led_mask: expected %0h, got %0h", fw.mask, tdata[25:16]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit             src_gaps = 1'b1;
  bit             sink_gaps = 1'b1;
  int             cycles = 0;
  led_frame_model frames = new();

  led_bar_frame_sequencer_top #(.NUM_LEDS(NUM_LEDS)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= !rst && (!sink_gaps || $urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      frames.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("led_bar_frame_sequencer_top: mismatch");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_command(logic [FUNC_W-1:0] func,
                                                        logic [INDEX_W-1:0] idx,
                                                        logic [MASK_W-1:0] smask,
                                                        logic [LEVEL_W-1:0] lvl);
    return IN_DATA_W'({lvl, smask, idx, func});
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_command();
    logic [INDEX_W-1:0] idx;
    logic [LEVEL_W-1:0] lvl;
    idx = ($urandom_range(0, 9) < 7) ? INDEX_W'($urandom_range(0, NUM_LEDS - 1))
                                     : INDEX_W'($urandom_range(0, 255));
    lvl = ($urandom_range(0, 9) < 7) ? LEVEL_W'($urandom_range(0, NUM_LEDS + 1))
                                     : LEVEL_W'($urandom_range(0, 255));
    return pack_command(FUNC_W'($urandom_range(0, 7)), idx, MASK_W'($urandom), lvl);
  endfunction

  task automatic send_command(logic [IN_DATA_W-1:0] data);
    while (src_gaps && $urandom_range(0, 99) < 25) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    frames.apply_command(data);
  endtask

  task automatic finish_frames();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    frames.write_reg(idx, data);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_command(pack_command(FUNC_ON, 8'd0, '0, '0));
    send_command(pack_command(FUNC_ON, 8'd9, '0, '0));
    send_command(pack_command(FUNC_ON, 8'd10, '0, '0));
    send_command(pack_command(FUNC_ON, 8'd255, '1, '1));
    send_command(pack_command(FUNC_TOGGLE, 8'd0, '0, '0));
    send_command(pack_command(FUNC_TOGGLE, 8'd5, '0, '0));
    send_command(pack_command(FUNC_OFF, 8'd9, '0, '0));
    send_command(pack_command(FUNC_OFF, 8'd200, '0, '0));
    send_command(pack_command(FUNC_TOGGLE, 8'd10, '0, '0));
    send_command(pack_command(FUNC_ALL_ON, '0, '0, '0));
    send_command(pack_command(FUNC_TOGGLE_ALL, '0, '0, '0));
    send_command(pack_command(FUNC_ALL_OFF, '0, '0, '0));
    send_command(pack_command(FUNC_SET_MASK, '0, 10'h3FF, '0));
    send_command(pack_command(FUNC_SET_MASK, '0, 10'h155, '0));
    send_command(pack_command(FUNC_SET_LEVEL, '0, '0, 8'd0));
    send_command(pack_command(FUNC_SET_LEVEL, '0, '0, 8'd5));
    send_command(pack_command(FUNC_SET_LEVEL, '0, '0, 8'd255));
    finish_frames();

    program_reg(REG_BRIGHTNESS, 16'd255);
    program_reg(REG_COMMAND_WORD, 16'hFFFF);
    send_command(pack_command(FUNC_SET_LEVEL, '0, '0, 8'd10));
    send_command(pack_command(FUNC_TOGGLE, 8'd4, '0, '0));
    finish_frames();

    program_reg(REG_BRIGHTNESS, 16'd0);
    program_reg(REG_COMMAND_WORD, 16'h0000);
    send_command(pack_command(FUNC_ALL_OFF, '0, '0, '0));
    send_command(pack_command(FUNC_ON, 8'd3, '0, '0));
    send_command(pack_command(FUNC_TOGGLE, 8'd3, '0, '0));
    send_command(pack_command(FUNC_SET_MASK, '0, 10'h2AA, '0));

    for (int phase = 0; phase < 4; phase++) begin
      finish_frames();
      program_reg(REG_BRIGHTNESS, CFG_DATA_W'($urandom_range(0, 255)));
      program_reg(REG_COMMAND_WORD, CFG_DATA_W'($urandom));
      src_gaps  = (phase != 1);
      sink_gaps = (phase != 1);
      repeat (90) send_command(random_command());
    end

    finish_frames();
    repeat (20) @(posedge clk);
    if (frames.errors == 0) begin
      $display("led_bar_frame_sequencer_top: match");
    end else begin
      $display("led_bar_frame_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule

### led_bar_frame_sequencer_top.f
hw/rtl/lbfs_pkg.sv
hw/rtl/lbfs_cell.sv
hw/rtl/lbfs_ctrl.sv
hw/rtl/led_bar_frame_sequencer_top.sv
sim/led_bar_frame_sequencer_top_test.sv
